### src/cpms_pkg.sv
package cpms_pkg;

   localparam int NUM_TYPES_DEF = 256;
   localparam int TYPE_BITS     = 8;
   localparam int VALUE_BITS    = 16;
   localparam int PROD_BITS     = 2 * VALUE_BITS;
   localparam int AMT_BITS      = 48;

   localparam logic KIND_SCORE = 1'b0;
   localparam logic KIND_BIN   = 1'b1;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_CONTACT = 2'd1,
      OP_READ    = 2'd2,
      OP_START   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_BIN_A,
      ST_BIN_B,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [TYPE_BITS-1:0] row;
      logic [TYPE_BITS-1:0] col;
   } tbl_ctrl_type;

   typedef struct packed {
      logic                 clear;
      logic                 rd_en;
      logic [TYPE_BITS-1:0] rd_idx;
      logic                 wr_en;
      logic [TYPE_BITS-1:0] wr_idx;
   } bin_ctrl_type;

   // saturating add on the signed q32.16 range
   function automatic logic signed [AMT_BITS-1:0] sat_add(
      input logic signed [AMT_BITS-1:0] acc,
      input logic signed [AMT_BITS-1:0] inc
   );
      logic signed [AMT_BITS:0]   sum;
      logic signed [AMT_BITS-1:0] res;
      sum = (AMT_BITS+1)'(acc) + (AMT_BITS+1)'(inc);
      if (sum[AMT_BITS] != sum[AMT_BITS-1]) begin
         res = sum[AMT_BITS] ? {1'b1, {(AMT_BITS-1){1'b0}}} : {1'b0, {(AMT_BITS-1){1'b1}}};
      end else begin
         res = sum[AMT_BITS-1:0];
      end
      return res;
   endfunction

endpackage

### src/cpms_if.sv
interface cpms_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [7:0]         type_a;
   logic [7:0]         type_b;
   logic signed [15:0] value;
   logic               last_item;

   modport source (output valid, op, type_a, type_b, value, last_item, input ready);
   modport sink   (input valid, op, type_a, type_b, value, last_item, output ready);
endinterface

interface cpms_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [7:0]         index;
   logic signed [47:0] amount;

   modport source (output valid, kind, index, amount, input ready);
   modport sink   (input valid, kind, index, amount, output ready);
endinterface

### src/contact_pair_matrix_scorer.sv
// Pair-coefficient contact scorer. The coefficient table lives in one synchronous
// memory and the 256 activation bins in a second one with a single read and a single
// write port; the running total is a register. A table write or a start op completes
// on acceptance; a bin read passes through an emit state, and a contact runs in steps:
// table lookup, multiply, then a read-modify-write of the first bin and of the second
// bin through the one bin read port. A contact that ends a set then passes through the
// emit state to load the score into the output register. A finished result sits in that
// register and blocks the block only if a new result is due before the old one has been taken.
module contact_pair_matrix_scorer
   import cpms_pkg::*;
#(
   parameter int NUM_TYPES = NUM_TYPES_DEF
) (
   input logic        clock,
   input logic        reset,
   cpms_req_if.sink   req_ch,
   cpms_rsp_if.source rsp_ch
);

   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   logic [TYPE_BITS-1:0]       ta_ff, ta_in;
   logic [TYPE_BITS-1:0]       tb_ff, tb_in;
   logic signed [VALUE_BITS-1:0] val_ff, val_in;
   logic                       last_ff, last_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [AMT_BITS-1:0] fwd_ff, fwd_in;
   logic signed [AMT_BITS-1:0] total_ff, total_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   logic [TYPE_BITS-1:0]       rsp_index_ff, rsp_index_in;
   logic signed [AMT_BITS-1:0] rsp_amount_ff, rsp_amount_in;

   tbl_ctrl_type               tbl_ctrl;
   bin_ctrl_type               bin_ctrl;
   logic signed [VALUE_BITS-1:0] tbl_rd_data;
   logic signed [AMT_BITS-1:0] bin_wr_data;
   logic signed [AMT_BITS-1:0] bin_rd_amount;
   logic signed [AMT_BITS-1:0] prod_ext;
   logic signed [AMT_BITS-1:0] sum_a;
   logic signed [AMT_BITS-1:0] old_b;
   logic                       req_transfer;
   logic                       req_in_range;
   logic                       item_in_range;
   logic                       a_in_range;
   logic                       rsp_free;

   cpms_pair_table #(.NUM_TYPES(NUM_TYPES)) u_table (
      .clock   (clock),
      .ctrl    (tbl_ctrl),
      .wr_data (req_ch.value),
      .rd_data (tbl_rd_data)
   );

   cpms_bin_store #(.NUM_TYPES(NUM_TYPES)) u_bins (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (bin_ctrl),
      .wr_data   (bin_wr_data),
      .rd_amount (bin_rd_amount)
   );

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign req_transfer  = req_ch.valid && req_ch.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_ch.ready;

   assign req_in_range  = ({1'b0, req_ch.type_a} < (TYPE_BITS+1)'(NUM_TYPES))
                       && ({1'b0, req_ch.type_b} < (TYPE_BITS+1)'(NUM_TYPES));
   assign a_in_range    = ({1'b0, ta_ff} < (TYPE_BITS+1)'(NUM_TYPES));
   assign item_in_range = a_in_range && ({1'b0, tb_ff} < (TYPE_BITS+1)'(NUM_TYPES));

   assign prod_ext = AMT_BITS'(prod_ff);
   assign sum_a    = sat_add(bin_rd_amount, prod_ext);
   // same type twice: the first bin update is not yet visible on the read port
   assign old_b    = (tb_ff == ta_ff) ? fwd_ff : bin_rd_amount;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_transfer) begin
               unique case (op_type'(req_ch.op))
                  OP_WRITE, OP_START: state_in = ST_IDLE;
                  OP_READ:            state_in = ST_EMIT;
                  OP_CONTACT: begin
                     if (req_in_range) begin
                        state_in = ST_LOOK;
                     end else if (req_ch.last_item) begin
                        state_in = ST_EMIT;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOOK:  state_in = ST_BIN_A;
         ST_BIN_A: state_in = ST_BIN_B;
         ST_BIN_B: state_in = last_ff ? ST_EMIT : ST_IDLE;
         ST_EMIT:  state_in = rsp_free ? ST_IDLE : ST_EMIT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in         = op_ff;
      ta_in         = ta_ff;
      tb_in         = tb_ff;
      val_in        = val_ff;
      last_in       = last_ff;
      prod_in       = prod_ff;
      fwd_in        = fwd_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_amount_in = rsp_amount_ff;
      tbl_ctrl      = '{wr_en: 1'b0, rd_en: 1'b0, row: req_ch.type_a, col: req_ch.type_b};
      bin_ctrl      = '{clear: 1'b0, rd_en: 1'b0, rd_idx: ta_ff, wr_en: 1'b0, wr_idx: ta_ff};
      bin_wr_data   = sum_a;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_transfer) begin
               op_in   = op_type'(req_ch.op);
               ta_in   = req_ch.type_a;
               tb_in   = req_ch.type_b;
               val_in  = req_ch.value;
               last_in = req_ch.last_item;
               unique case (op_type'(req_ch.op))
                  OP_WRITE:   tbl_ctrl.wr_en = req_in_range;
                  OP_CONTACT: tbl_ctrl.rd_en = req_in_range;
                  OP_READ: begin
                     bin_ctrl.rd_en  = 1'b1;
                     bin_ctrl.rd_idx = req_ch.type_a;
                  end
                  OP_START: begin
                     bin_ctrl.clear = 1'b1;
                     total_in       = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOOK: begin
            prod_in         = tbl_rd_data * val_ff;
            bin_ctrl.rd_en  = 1'b1;
            bin_ctrl.rd_idx = ta_ff;
         end
         ST_BIN_A: begin
            bin_ctrl.wr_en  = 1'b1;
            bin_ctrl.wr_idx = ta_ff;
            bin_wr_data     = sum_a;
            fwd_in          = sum_a;
            total_in        = sat_add(total_ff, prod_ext);
            bin_ctrl.rd_en  = 1'b1;
            bin_ctrl.rd_idx = tb_ff;
         end
         ST_BIN_B: begin
            bin_ctrl.wr_en  = 1'b1;
            bin_ctrl.wr_idx = tb_ff;
            bin_wr_data     = sat_add(old_b, prod_ext);
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (op_ff == OP_READ) begin
                  rsp_kind_in   = KIND_BIN;
                  rsp_index_in  = ta_ff;
                  rsp_amount_in = a_in_range ? bin_rd_amount : '0;
               end else begin
                  rsp_kind_in   = KIND_SCORE;
                  rsp_index_in  = '0;
                  rsp_amount_in = total_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      ta_ff         <= ta_in;
      tb_ff         <= tb_in;
      val_ff        <= val_in;
      last_ff       <= last_in;
      prod_ff       <= (item_in_range || state_ff != ST_LOOK) ? prod_in : '0;
      fwd_ff        <= fwd_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_amount_ff <= rsp_amount_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.kind   = rsp_kind_ff;
   assign rsp_ch.index  = rsp_index_ff;
   assign rsp_ch.amount = rsp_amount_ff;

endmodule

### src/cpms_pair_table.sv
module cpms_pair_table
   import cpms_pkg::*;
#(
   parameter int NUM_TYPES = NUM_TYPES_DEF
) (
   input  logic                         clock,
   input  tbl_ctrl_type                 ctrl,
   input  logic signed [VALUE_BITS-1:0] wr_data,
   output logic signed [VALUE_BITS-1:0] rd_data
);

   localparam int DEPTH  = NUM_TYPES * NUM_TYPES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TYPE_W = $clog2(NUM_TYPES);

   logic signed [VALUE_BITS-1:0] mem [DEPTH];
   logic signed [VALUE_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]            addr;

   // row-major entry address
   assign addr = ADDR_W'(ctrl.row[TYPE_W-1:0]) * ADDR_W'(NUM_TYPES)
               + ADDR_W'(ctrl.col[TYPE_W-1:0]);

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/cpms_bin_store.sv
module cpms_bin_store
   import cpms_pkg::*;
#(
   parameter int NUM_TYPES = NUM_TYPES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bin_ctrl_type               ctrl,
   input  logic signed [AMT_BITS-1:0] wr_data,
   output logic signed [AMT_BITS-1:0] rd_amount
);

   localparam int TYPE_W = $clog2(NUM_TYPES);

   logic signed [AMT_BITS-1:0] mem [NUM_TYPES];
   logic [NUM_TYPES-1:0]       valid_ff;
   logic [NUM_TYPES-1:0]       valid_in;
   logic signed [AMT_BITS-1:0] rd_data_ff;
   logic                       rd_valid_ff;
   logic [TYPE_W-1:0]          rd_idx;
   logic [TYPE_W-1:0]          wr_idx;

   assign rd_idx = ctrl.rd_idx[TYPE_W-1:0];
   assign wr_idx = ctrl.wr_idx[TYPE_W-1:0];

   // a bin not hit since the last start reads as zero
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = '0;
      end else if (ctrl.wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff  <= mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   assign rd_amount = rd_valid_ff ? rd_data_ff : '0;

endmodule

### src/cpms_checker.sv
module cpms_checker
   import cpms_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [1:0]                 req_op,
   input logic [TYPE_BITS-1:0]       req_type_a,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_kind,
   input logic [TYPE_BITS-1:0]       rsp_index,
   input logic signed [AMT_BITS-1:0] rsp_amount
);

   logic req_transfer;
   assign req_transfer = req_valid && req_ready;

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
                                  && $stable(rsp_index) && $stable(rsp_amount))
      else $error("stalled result changed");

   // score results carry index zero
   a_score_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SCORE |-> rsp_index == '0)
      else $error("score result with nonzero index");

   // a bin read into an empty output passes the emit state and the output register, then shows up for that bin
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      req_transfer && req_op == OP_READ && !rsp_valid
      |=> ##1 rsp_valid && rsp_kind == KIND_BIN && rsp_index == $past(req_type_a, 2))
      else $error("bin readout missing or wrong index");

   // table writes and starts finish in the cycle they are taken
   a_single_cycle: assert property (@(posedge clock) disable iff (reset)
      req_transfer && (req_op == OP_WRITE || req_op == OP_START) |=> req_ready)
      else $error("single-cycle op held the input");

endmodule

bind contact_pair_matrix_scorer cpms_checker u_cpms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_op     (req_ch.op),
   .req_type_a (req_ch.type_a),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_kind   (rsp_ch.kind),
   .rsp_index  (rsp_ch.index),
   .rsp_amount (rsp_ch.amount)
);

### sim/cpms_scorer_checker.sv
`timescale 1ns / 1ps

module cpms_scorer_checker
   import cpms_pkg::*;
#(
   parameter int NUM_TYPES = NUM_TYPES_DEF
) (
   input  logic clock,
   input  logic reset,
   cpms_req_if  req_ch,
   cpms_rsp_if  rsp_ch,
   output int   fail_count,
   output int   outstanding
);

   typedef struct packed {
      logic                 kind;
      logic [TYPE_BITS-1:0] index;
      logic [AMT_BITS-1:0]  amount;
   } score_rec;

   localparam logic signed [AMT_BITS:0] AMT_HI = {2'b00, {(AMT_BITS-1){1'b1}}};
   localparam logic signed [AMT_BITS:0] AMT_LO = {2'b11, {(AMT_BITS-1){1'b0}}};

   logic signed [VALUE_BITS-1:0] coef_mem [NUM_TYPES*NUM_TYPES];
   logic signed [AMT_BITS-1:0]   bin_acc [NUM_TYPES];
   logic                         bin_hit [NUM_TYPES];
   logic signed [AMT_BITS-1:0]   run_total;
   score_rec                     due_results [$];
   int                           shown;

   // clamp the 49-bit sum back into the q32.16 range
   function automatic logic signed [AMT_BITS-1:0] clip_add(
      input logic signed [AMT_BITS-1:0] a,
      input logic signed [AMT_BITS-1:0] b
   );
      logic signed [AMT_BITS:0] s;
      s = a + b;
      if (s > AMT_HI) begin
         s = AMT_HI;
      end else if (s < AMT_LO) begin
         s = AMT_LO;
      end
      return s[AMT_BITS-1:0];
   endfunction

   task automatic clear_bins();
      run_total = '0;
      for (int i = 0; i < NUM_TYPES; i++) begin
         bin_acc[i] = '0;
         bin_hit[i] = 1'b0;
      end
   endtask

   task automatic touch_bin(input int t, input logic signed [AMT_BITS-1:0] inc);
      if (!bin_hit[t]) begin
         bin_acc[t] = '0;
         bin_hit[t] = 1'b1;
      end
      bin_acc[t] = clip_add(bin_acc[t], inc);
   endtask

   task automatic score_item(
      input op_type                       op,
      input logic [TYPE_BITS-1:0]         ta,
      input logic [TYPE_BITS-1:0]         tb,
      input logic signed [VALUE_BITS-1:0] val,
      input logic                         last
   );
      logic signed [PROD_BITS-1:0] prod;
      logic signed [AMT_BITS-1:0]  inc;
      logic signed [AMT_BITS-1:0]  amt;
      bit                          in_range;
      in_range = (int'(ta) < NUM_TYPES) && (int'(tb) < NUM_TYPES);
      case (op)
         OP_WRITE: begin
            if (in_range) coef_mem[int'(ta) * NUM_TYPES + int'(tb)] = val;
         end
         OP_CONTACT: begin
            if (in_range) begin
               prod = coef_mem[int'(ta) * NUM_TYPES + int'(tb)] * val;
               inc = prod;
               run_total = clip_add(run_total, inc);
               touch_bin(int'(ta), inc);
               touch_bin(int'(tb), inc);
            end
            if (last) due_results.push_back('{KIND_SCORE, '0, run_total});
         end
         OP_READ: begin
            amt = '0;
            if (int'(ta) < NUM_TYPES && bin_hit[ta]) amt = bin_acc[ta];
            due_results.push_back('{KIND_BIN, ta, amt});
         end
         default: begin
            clear_bins();
         end
      endcase
   endtask

   always @(posedge clock) begin
      score_rec got;
      score_rec want;
      if (reset) begin
         clear_bins();
         due_results.delete();
      end else begin
         // results first: nothing accepted at this edge can answer at this edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.kind, rsp_ch.index, rsp_ch.amount};
            if (due_results.size() == 0) begin
               fail_count++;
               if (shown < 10) begin
                  $display("%0t: unexpected result kind %0d index %0d amount %0d", $realtime,
                     got.kind, got.index, $signed(got.amount));
               end
               shown++;
            end else begin
               want = due_results.pop_front();
               if (got.kind !== want.kind || got.index !== want.index ||
                   got.amount !== want.amount) begin
                  fail_count++;
                  if (shown < 10) begin
                     $display("%0t: result mismatch: expected kind %0d index %0d amount %0d, got kind %0d index %0d amount %0d",
                        $realtime, want.kind, want.index, $signed(want.amount),
                        got.kind, got.index, $signed(got.amount));
                  end
                  shown++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            score_item(op_type'(req_ch.op), req_ch.type_a, req_ch.type_b, req_ch.value,
               req_ch.last_item);
         end
      end
      outstanding = due_results.size();
   end

endmodule

### sim/tb_contact_pair_matrix_scorer.sv
`timescale 1ns / 1ps

module tb_contact_pair_matrix_scorer;
   import cpms_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int GAP_MAX      = 5;
   localparam int RANDOM_ITEMS = 1800;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cpms_req_if req_ch ();
   cpms_rsp_if rsp_ch ();

   int   fail_count;
   int   outstanding;
   bit   quiet;
   int   sent;
   int   idle_cycles;
   bit   key_seen [65536];
   logic [15:0] written_keys [$];

   contact_pair_matrix_scorer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   cpms_scorer_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[contact_pair_matrix_scorer] ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // result side: random stall before each transfer
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_item(
      input op_type             op,
      input logic [7:0]         ta,
      input logic [7:0]         tb,
      input logic signed [15:0] val,
      input logic               last
   );
      int gap;
      gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.op        = op;
      req_ch.type_a    = ta;
      req_ch.type_b    = tb;
      req_ch.value     = val;
      req_ch.last_item = last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (op == OP_WRITE && !key_seen[{ta, tb}]) begin
         key_seen[{ta, tb}] = 1'b1;
         written_keys.push_back({ta, tb});
      end
      sent++;
      @(negedge clock);
   endtask

   // only entries already written may be looked up
   function automatic logic [15:0] pick_pair();
      return written_keys[$urandom_range(0, written_keys.size() - 1)];
   endfunction

   // half uniform, half a small pool near both ends so bins collide
   function automatic logic [7:0] pick_type();
      if ($urandom_range(0, 1)) return 8'($urandom);
      return ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(0, 3));
   endfunction

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] key;
      int          base;
      int          n;
      op_type      op;
      req_ch.valid     = 1'b0;
      req_ch.op        = OP_WRITE;
      req_ch.type_a    = '0;
      req_ch.type_b    = '0;
      req_ch.value     = '0;
      req_ch.last_item = 1'b0;
      quiet            = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, equal types, ignored last_item, cleared bins
      send_item(OP_READ,    8'd0,   8'd0,   16'sh0000, 1'b1);
      send_item(OP_WRITE,   8'd0,   8'd0,   16'sh7FFF, 1'b0);
      send_item(OP_WRITE,   8'd255, 8'd255, 16'sh8000, 1'b1);
      send_item(OP_WRITE,   8'd0,   8'd255, 16'sh0100, 1'b0);
      send_item(OP_WRITE,   8'd255, 8'd0,   16'shFFFF, 1'b0);
      send_item(OP_CONTACT, 8'd0,   8'd255, 16'sh7FFF, 1'b0);
      send_item(OP_CONTACT, 8'd255, 8'd255, 16'sh8000, 1'b1);
      send_item(OP_CONTACT, 8'd255, 8'd0,   16'shFFFF, 1'b1);
      send_item(OP_CONTACT, 8'd0,   8'd0,   16'sh8000, 1'b1);
      send_item(OP_READ,    8'd0,   8'd0,   16'sh0000, 1'b0);
      send_item(OP_READ,    8'd255, 8'd0,   16'sh0000, 1'b0);
      send_item(OP_READ,    8'd7,   8'd0,   16'sh0000, 1'b0);
      send_item(OP_START,   8'd0,   8'd0,   16'sh0000, 1'b1);
      send_item(OP_READ,    8'd0,   8'd0,   16'sh0000, 1'b0);
      send_item(OP_CONTACT, 8'd0,   8'd0,   16'sh0000, 1'b1);
      send_item(OP_READ,    8'd0,   8'd0,   16'sh0000, 1'b1);
      send_item(OP_WRITE,   8'd0,   8'd0,   16'sh0000, 1'b0);
      send_item(OP_CONTACT, 8'd0,   8'd0,   16'sh7FFF, 1'b1);
      send_item(OP_READ,    8'd255, 8'd255, 16'sh7FFF, 1'b1);

      // random: mostly complete sets, some noise
      base = sent;
      while (sent - base < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 9) < 7) begin
            send_item(OP_START, pick_type(), pick_type(), pick_value(), 1'($urandom));
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
               send_item(OP_WRITE, pick_type(), pick_type(), pick_value(), 1'($urandom));
            end
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
               key = pick_pair();
               send_item(OP_CONTACT, key[15:8], key[7:0], pick_value(), i == n - 1);
            end
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
               key = pick_pair();
               send_item(OP_READ, $urandom_range(0, 1) ? key[15:8] : pick_type(), 8'($urandom),
                  pick_value(), 1'($urandom));
            end
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               op = op_type'($urandom_range(0, 3));
               key = (op == OP_CONTACT) ? pick_pair() : 16'($urandom);
               send_item(op, key[15:8], key[7:0], pick_value(), 1'($urandom));
            end
         end
      end
      quiet = 1'b0;
      req_ch.valid = 1'b0;

      wait (outstanding == 0);
      repeat (30) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("[contact_pair_matrix_scorer] OK");
      end else begin
         $display("[contact_pair_matrix_scorer] ERROR");
      end
      $finish;
   end

endmodule
